@@ hw/rtl/kbr_pkg.sv @@
// Shared types, codes and helpers for the K-line block receiver.
package kbr_pkg;

  localparam logic [7:0] ANSWER_BASE = 8'hFF;
  localparam logic [7:0] END_BYTE    = 8'h03;
  localparam logic [7:0] TITLE_ACK   = 8'h09;
  localparam logic [7:0] TITLE_ZERO  = 8'h00;
  localparam logic [7:0] COUNT_MAX   = 8'd255;
  localparam logic [7:0] COUNT_FIRST = 8'd1;
  localparam logic [7:0] MIN_LENGTH  = 8'd3;

  typedef enum logic [1:0] {
    CMD_UNIT_BYTE = 2'd0,
    CMD_ECHO      = 2'd1,
    CMD_OWN_SENT  = 2'd2,
    CMD_START     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_CNT   = 3'd1,
    PH_TITLE = 3'd2,
    PH_DATA  = 3'd3,
    PH_END   = 3'd4,
    PH_ECHO  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ECHO    = 3'd1,
    ERR_COUNTER = 3'd2,
    ERR_END     = 3'd3,
    ERR_SHORT   = 3'd4
  } err_t;

  typedef struct packed {
    phase_t     phase;
    phase_t     resume_phase;
    logic [7:0] bytes_left;
    logic [7:0] block_counter;
    logic       ready_flag;
    logic [7:0] expected_echo;
    logic [7:0] title_reg;
    logic [7:0] payload_pos;
  } state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_index;
    logic [7:0] data_byte;
    logic       block_done;
    logic [7:0] block_title;
    err_t       error_code;
    logic       ready_res;
    logic [7:0] counter_now;
  } result_t;

  // Wrap 255 (and the impossible 0) back to 1.
  function automatic logic [7:0] advance_count(input logic [7:0] c);
    if (c == COUNT_MAX || c == 8'd0) begin
      return COUNT_FIRST;
    end
    return c + 8'd1;
  endfunction

endpackage

@@ hw/rtl/kbr_step.sv @@
// Next-state and result logic for one received word.
module kbr_step (
  input  kbr_pkg::state_t  st,
  input  kbr_pkg::cmd_t    command,
  input  logic [7:0]       rx_byte,
  output kbr_pkg::state_t  st_next,
  output kbr_pkg::result_t res
);

  logic [7:0]        ans;
  logic [7:0]        left_dec;
  logic              tx_valid;
  logic              data_valid;
  logic              done;
  kbr_pkg::err_t     err;

  assign ans      = kbr_pkg::ANSWER_BASE - rx_byte;
  assign left_dec = (st.bytes_left != 8'd0) ? st.bytes_left - 8'd1 : 8'd0;

  always_comb begin
    st_next    = st;
    tx_valid   = 1'b0;
    data_valid = 1'b0;
    done       = 1'b0;
    err        = kbr_pkg::ERR_NONE;
    case (command)
      kbr_pkg::CMD_UNIT_BYTE: begin
        if (st.phase == kbr_pkg::PH_ECHO) begin
          err           = kbr_pkg::ERR_ECHO;
          st_next.phase = kbr_pkg::PH_LEN;
        end else if (st.phase == kbr_pkg::PH_END) begin
          if (rx_byte == kbr_pkg::END_BYTE) begin
            done                  = 1'b1;
            st_next.block_counter = kbr_pkg::advance_count(st.block_counter);
            if (st.title_reg == kbr_pkg::TITLE_ACK || st.title_reg == kbr_pkg::TITLE_ZERO) begin
              st_next.ready_flag = 1'b1;
            end
          end else begin
            err = kbr_pkg::ERR_END;
          end
          st_next.phase = kbr_pkg::PH_LEN;
        end else if (st.phase == kbr_pkg::PH_LEN && rx_byte < kbr_pkg::MIN_LENGTH) begin
          err = kbr_pkg::ERR_SHORT;
        end else begin
          tx_valid              = 1'b1;
          st_next.expected_echo = ans;
          case (st.phase)
            kbr_pkg::PH_LEN: begin
              st_next.bytes_left   = rx_byte - kbr_pkg::MIN_LENGTH;
              st_next.resume_phase = kbr_pkg::PH_CNT;
              st_next.phase        = kbr_pkg::PH_ECHO;
            end
            kbr_pkg::PH_CNT: begin
              if (rx_byte != st.block_counter) begin
                err           = kbr_pkg::ERR_COUNTER;
                st_next.phase = kbr_pkg::PH_LEN;
              end else begin
                st_next.resume_phase = kbr_pkg::PH_TITLE;
                st_next.phase        = kbr_pkg::PH_ECHO;
              end
            end
            kbr_pkg::PH_TITLE: begin
              st_next.title_reg    = rx_byte;
              st_next.payload_pos  = 8'd0;
              st_next.resume_phase = (st.bytes_left != 8'd0) ? kbr_pkg::PH_DATA
                                                             : kbr_pkg::PH_END;
              st_next.phase        = kbr_pkg::PH_ECHO;
            end
            kbr_pkg::PH_DATA: begin
              data_valid           = 1'b1;
              st_next.payload_pos  = st.payload_pos + 8'd1;
              st_next.bytes_left   = left_dec;
              st_next.resume_phase = (left_dec != 8'd0) ? kbr_pkg::PH_DATA
                                                        : kbr_pkg::PH_END;
              st_next.phase        = kbr_pkg::PH_ECHO;
            end
            default: begin
              // unknown phase: drop the word and recover
              tx_valid      = 1'b0;
              st_next.phase = kbr_pkg::PH_LEN;
            end
          endcase
        end
      end
      kbr_pkg::CMD_ECHO: begin
        if (st.phase == kbr_pkg::PH_ECHO) begin
          if (rx_byte == st.expected_echo) begin
            st_next.phase = st.resume_phase;
          end else begin
            err           = kbr_pkg::ERR_ECHO;
            st_next.phase = kbr_pkg::PH_LEN;
          end
        end
      end
      kbr_pkg::CMD_OWN_SENT: begin
        st_next.block_counter = kbr_pkg::advance_count(st.block_counter);
      end
      default: begin
        st_next.phase         = kbr_pkg::PH_LEN;
        st_next.resume_phase  = kbr_pkg::PH_LEN;
        st_next.bytes_left    = 8'd0;
        st_next.expected_echo = 8'd0;
        st_next.title_reg     = 8'd0;
        st_next.payload_pos   = 8'd0;
        st_next.block_counter = kbr_pkg::COUNT_FIRST;
        st_next.ready_flag    = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.tx_valid    = tx_valid;
    res.tx_byte     = tx_valid ? ans : 8'd0;
    res.data_valid  = data_valid;
    res.data_index  = data_valid ? st.payload_pos : 8'd0;
    res.data_byte   = data_valid ? rx_byte : 8'd0;
    res.block_done  = done;
    res.block_title = st_next.title_reg;
    res.error_code  = err;
    res.ready_res   = st_next.ready_flag;
    res.counter_now = st_next.block_counter;
  end

endmodule

@@ hw/rtl/kline_block_receiver.sv @@
// Top level of the K-line block receiver: state, result register, handshakes.
//
// Each input word (a unit byte, an echo, an own-block-sent or a session-start
// command) produces exactly one result word. The block state updates in the
// same cycle that the word is accepted, and the result is held in a single
// output register, so one word is taken every cycle; the only limit is the
// output side, and a new word is accepted whenever the output register is
// empty or is being emptied in that cycle. The result appears in the cycle
// after the word is accepted.
module kline_block_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       data_valid,
  output logic [7:0] data_index,
  output logic [7:0] data_byte,
  output logic       block_done,
  output logic [7:0] block_title,
  output logic [2:0] error_code,
  output logic       ready_res,
  output logic [7:0] counter_now
);

  kbr_pkg::state_t  st;
  kbr_pkg::state_t  st_next;
  kbr_pkg::result_t res_next;
  kbr_pkg::result_t res;
  logic             in_take;

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  kbr_step u_step (
    .st      (st),
    .command (kbr_pkg::cmd_t'(command)),
    .rx_byte (rx_byte),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= kbr_pkg::PH_LEN;
      st.resume_phase  <= kbr_pkg::PH_LEN;
      st.bytes_left    <= 8'd0;
      st.block_counter <= kbr_pkg::COUNT_FIRST;
      st.ready_flag    <= 1'b0;
      st.expected_echo <= 8'd0;
      st.title_reg     <= 8'd0;
      st.payload_pos   <= 8'd0;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result word while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      res <= res_next;
    end
  end

  assign tx_valid    = res.tx_valid;
  assign tx_byte     = res.tx_byte;
  assign data_valid  = res.data_valid;
  assign data_index  = res.data_index;
  assign data_byte   = res.data_byte;
  assign block_done  = res.block_done;
  assign block_title = res.block_title;
  assign error_code  = res.error_code;
  assign ready_res   = res.ready_res;
  assign counter_now = res.counter_now;

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> tx_valid && error_code == kbr_pkg::ERR_NONE)
    else $error("data word reported with error or without answer");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_done |-> !tx_valid && error_code == kbr_pkg::ERR_NONE)
    else $error("block end answered or flagged as error");

  a_counter_nz: assert property (@(posedge clk) disable iff (rst)
    st.block_counter != 8'd0)
    else $error("block counter reached zero");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    in_take && command == kbr_pkg::CMD_START |=>
      st.block_counter == kbr_pkg::COUNT_FIRST && !st.ready_flag &&
      st.phase == kbr_pkg::PH_LEN)
    else $error("session start did not clear block state");

endmodule

@@ tb/sv/tb_kline_block_receiver.sv @@
// Self-checking testbench for the K-line block receiver with a line-event predictor.
module tb_kline_block_receiver;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 790;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {FLAW_NONE, FLAW_ECHO, FLAW_COUNTER, FLAW_END, FLAW_SKIP} flaw_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = kbr_pkg::CMD_UNIT_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_index;
  logic [7:0] data_byte;
  logic       block_done;
  logic [7:0] block_title;
  logic [2:0] error_code;
  logic       ready_res;
  logic [7:0] counter_now;

  kline_block_receiver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .data_valid(data_valid),
    .data_index(data_index), .data_byte(data_byte), .block_done(block_done),
    .block_title(block_title), .error_code(error_code), .ready_res(ready_res),
    .counter_now(counter_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Link state as the block should hold it.
  kbr_pkg::phase_t link_phase = kbr_pkg::PH_LEN;
  kbr_pkg::phase_t after_echo = kbr_pkg::PH_LEN;
  logic [7:0] bytes_to_go = 8'h00;
  logic [7:0] count_now = kbr_pkg::COUNT_FIRST;
  logic       ready_now = 1'b0;
  logic [7:0] echo_want = 8'h00;
  logic [7:0] title_now = 8'h00;
  logic [7:0] data_pos = 8'h00;

  kbr_pkg::result_t awaited_words[$];
  int      words_sent = 0;
  int      results_checked = 0;
  int      blocks_done = 0;
  int      errors_flagged = 0;
  int      counter_wraps = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  logic    no_idle = 1'b0;
  logic    long_hold = 1'b0;

  function automatic logic [7:0] next_count(input logic [7:0] c);
    if (c == kbr_pkg::COUNT_MAX || c == 8'd0) begin
      counter_wraps++;
      return kbr_pkg::COUNT_FIRST;
    end
    return c + 8'd1;
  endfunction

  function automatic kbr_pkg::result_t apply_line_event(input kbr_pkg::cmd_t c,
                                                        input logic [7:0] b);
    kbr_pkg::result_t r;
    logic [7:0]       ans;
    r   = '0;
    ans = kbr_pkg::ANSWER_BASE - b;
    case (c)
      kbr_pkg::CMD_UNIT_BYTE: begin
        if (link_phase == kbr_pkg::PH_ECHO) begin
          r.error_code = kbr_pkg::ERR_ECHO;
          link_phase   = kbr_pkg::PH_LEN;
        end else if (link_phase == kbr_pkg::PH_END) begin
          if (b == kbr_pkg::END_BYTE) begin
            r.block_done = 1'b1;
            count_now    = next_count(count_now);
            if (title_now == kbr_pkg::TITLE_ACK || title_now == kbr_pkg::TITLE_ZERO) begin
              ready_now = 1'b1;
            end
          end else begin
            r.error_code = kbr_pkg::ERR_END;
          end
          link_phase = kbr_pkg::PH_LEN;
        end else if (link_phase == kbr_pkg::PH_LEN && b < kbr_pkg::MIN_LENGTH) begin
          r.error_code = kbr_pkg::ERR_SHORT;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte  = ans;
          echo_want  = ans;
          case (link_phase)
            kbr_pkg::PH_LEN: begin
              bytes_to_go = b - kbr_pkg::MIN_LENGTH;
              after_echo  = kbr_pkg::PH_CNT;
              link_phase  = kbr_pkg::PH_ECHO;
            end
            kbr_pkg::PH_CNT: begin
              if (b != count_now) begin
                r.error_code = kbr_pkg::ERR_COUNTER;
                link_phase   = kbr_pkg::PH_LEN;
              end else begin
                after_echo = kbr_pkg::PH_TITLE;
                link_phase = kbr_pkg::PH_ECHO;
              end
            end
            kbr_pkg::PH_TITLE: begin
              title_now  = b;
              data_pos   = 8'h00;
              after_echo = (bytes_to_go != 8'h00) ? kbr_pkg::PH_DATA : kbr_pkg::PH_END;
              link_phase = kbr_pkg::PH_ECHO;
            end
            kbr_pkg::PH_DATA: begin
              r.data_valid = 1'b1;
              r.data_index = data_pos;
              r.data_byte  = b;
              data_pos     = data_pos + 8'd1;
              if (bytes_to_go != 8'h00) bytes_to_go = bytes_to_go - 8'd1;
              after_echo = (bytes_to_go != 8'h00) ? kbr_pkg::PH_DATA : kbr_pkg::PH_END;
              link_phase = kbr_pkg::PH_ECHO;
            end
            default: begin
              r.tx_valid = 1'b0;
              r.tx_byte  = 8'h00;
              link_phase = kbr_pkg::PH_LEN;
            end
          endcase
        end
      end
      kbr_pkg::CMD_ECHO: begin
        if (link_phase == kbr_pkg::PH_ECHO) begin
          if (b == echo_want) begin
            link_phase = after_echo;
          end else begin
            r.error_code = kbr_pkg::ERR_ECHO;
            link_phase   = kbr_pkg::PH_LEN;
          end
        end
      end
      kbr_pkg::CMD_OWN_SENT: count_now = next_count(count_now);
      default: begin
        link_phase  = kbr_pkg::PH_LEN;
        after_echo  = kbr_pkg::PH_LEN;
        bytes_to_go = 8'h00;
        echo_want   = 8'h00;
        title_now   = 8'h00;
        data_pos    = 8'h00;
        count_now   = kbr_pkg::COUNT_FIRST;
        ready_now   = 1'b0;
      end
    endcase
    r.block_title = title_now;
    r.ready_res   = ready_now;
    r.counter_now = count_now;
    if (r.block_done) blocks_done++;
    if (r.error_code != kbr_pkg::ERR_NONE) errors_flagged++;
    return r;
  endfunction

  // Offer one word after a drawn gap; record its expected result once taken.
  task automatic send_word(input kbr_pkg::cmd_t c, input logic [7:0] b);
    int   gap;
    logic stalled;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    rx_byte  <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    awaited_words.push_back(apply_line_event(c, b));
    words_sent++;
  endtask

  // Send a block with echoes; a flaw breaks it at one point and drops the rest.
  task automatic send_block(input logic [7:0] len, input logic [7:0] ttl, input flaw_t flaw);
    int         n;
    int         spot;
    logic [7:0] b;
    n    = int'(len) - 3;
    spot = $urandom_range(0, n + 2);
    for (int i = 0; i < n + 3; i++) begin
      if (i == 0) b = len;
      else if (i == 1) b = (flaw == FLAW_COUNTER) ? count_now + 8'd1 : count_now;
      else if (i == 2) b = ttl;
      else b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 31) == 0) begin
        send_word(kbr_pkg::CMD_OWN_SENT, 8'($urandom_range(0, 255)));
      end
      if (i == 1) b = (flaw == FLAW_COUNTER) ? count_now + 8'd1 : count_now;
      send_word(kbr_pkg::CMD_UNIT_BYTE, b);
      if (flaw == FLAW_COUNTER && i == 1) begin
        // the answer's echo now arrives outside an echo wait
        send_word(kbr_pkg::CMD_ECHO, kbr_pkg::ANSWER_BASE - b);
        return;
      end
      if (flaw == FLAW_ECHO && i == spot) begin
        send_word(kbr_pkg::CMD_ECHO,
                  (kbr_pkg::ANSWER_BASE - b) ^ (8'h01 << $urandom_range(0, 7)));
        return;
      end
      if (flaw == FLAW_SKIP && i == spot) begin
        send_word(kbr_pkg::CMD_UNIT_BYTE, 8'($urandom_range(0, 255)));
        return;
      end
      send_word(kbr_pkg::CMD_ECHO, kbr_pkg::ANSWER_BASE - b);
    end
    b = kbr_pkg::END_BYTE;
    if (flaw == FLAW_END) begin
      b = 8'($urandom_range(0, 255));
      if (b == kbr_pkg::END_BYTE) b = 8'h04;
    end
    send_word(kbr_pkg::CMD_UNIT_BYTE, b);
  endtask

  task automatic test_short_length();
    send_word(kbr_pkg::CMD_UNIT_BYTE, 8'h00);
    send_word(kbr_pkg::CMD_UNIT_BYTE, 8'h01);
    send_word(kbr_pkg::CMD_UNIT_BYTE, 8'h02);
    send_word(kbr_pkg::CMD_ECHO, 8'hFF);
  endtask

  task automatic test_ack_block();
    send_block(kbr_pkg::MIN_LENGTH, kbr_pkg::TITLE_ACK, FLAW_NONE);
    send_word(kbr_pkg::CMD_START, 8'hFF);
  endtask

  task automatic test_block_errors();
    send_block(8'd6, 8'h5A, FLAW_COUNTER);
    send_block(kbr_pkg::MIN_LENGTH, 8'hA5, FLAW_ECHO);
    send_block(kbr_pkg::MIN_LENGTH, kbr_pkg::TITLE_ZERO, FLAW_END);
    send_block(8'd4, 8'hFF, FLAW_SKIP);
    send_word(kbr_pkg::CMD_OWN_SENT, 8'h00);
  endtask

  task automatic test_counter_wrap();
    while (count_now != kbr_pkg::COUNT_MAX) begin
      send_word(kbr_pkg::CMD_OWN_SENT, 8'($urandom_range(0, 255)));
    end
    send_block(8'd3 + 8'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), FLAW_NONE);
  endtask

  task automatic test_longest_block();
    send_block(8'd255, kbr_pkg::TITLE_ZERO, FLAW_NONE);
  endtask

  // Hold the result side for a long stretch while words keep coming back to back.
  task automatic test_backpressure();
    no_idle   = 1'b1;
    long_hold = 1'b1;
    send_block(8'd20, 8'($urandom_range(0, 255)), FLAW_NONE);
    no_idle   = 1'b0;
  endtask

  task automatic test_random_traffic();
    int         first;
    int         pick;
    logic [7:0] len;
    logic [7:0] ttl;
    flaw_t      flaw;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 78) begin
        len = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(3, 10))
                                          : 8'($urandom_range(11, 40));
        case ($urandom_range(0, 7))
          0, 1:    ttl = kbr_pkg::TITLE_ACK;
          2:       ttl = kbr_pkg::TITLE_ZERO;
          default: ttl = 8'($urandom_range(0, 255));
        endcase
        flaw = ($urandom_range(0, 4) == 0) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
        send_block(len, ttl, flaw);
      end else if (pick < 98) begin
        case ($urandom_range(0, 4))
          0:       send_word(kbr_pkg::CMD_UNIT_BYTE, 8'($urandom_range(0, 2)));
          1:       send_word(kbr_pkg::CMD_ECHO, 8'($urandom_range(0, 255)));
          2:       send_word(kbr_pkg::CMD_OWN_SENT, 8'($urandom_range(0, 255)));
          3:       send_word(kbr_pkg::CMD_UNIT_BYTE, 8'($urandom_range(0, 255)));
          default: send_word(kbr_pkg::cmd_t'($urandom_range(0, 2)),
                             8'($urandom_range(0, 255)));
        endcase
      end else begin
        send_word(kbr_pkg::CMD_START, 8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: stall for a drawn spell, or for the long hold when one is asked, then take one word.
  initial begin : result_sink
    int   hold;
    logic got;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = (out_valid === 1'b1);
        @(posedge clk);
      end while (!got);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare on the falling edge, where a word about to be taken is stable.
  always @(negedge clk) begin : compare_results
    kbr_pkg::result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: result word with none expected", $time);
        mismatches++;
      end else begin
        want = awaited_words.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
        check_field("data_index", want.data_index, data_index);
        check_field("data_byte", want.data_byte, data_byte);
        check_field("block_done", 8'(want.block_done), 8'(block_done));
        check_field("block_title", want.block_title, block_title);
        check_field("error_code", 8'(want.error_code), 8'(error_code));
        check_field("ready_res", 8'(want.ready_res), 8'(ready_res));
        check_field("counter_now", want.counter_now, counter_now);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_short_length();
    test_ack_block();
    test_block_errors();
    test_counter_wrap();
    test_longest_block();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d mismatching fields",
             words_sent, results_checked, mismatches);
    $display("%0d blocks completed, %0d errors flagged, %0d counter wraps",
             blocks_done, errors_flagged, counter_wraps);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/kbr_pkg.sv
hw/rtl/kbr_step.sv
hw/rtl/kline_block_receiver.sv
tb/sv/tb_kline_block_receiver.sv
